### hdl/qpht_pkg.sv
`timescale 1ns / 1ps

package qpht_pkg;

    // default geometry
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int IDX_W_DEF       = $clog2(TABLE_DEPTH_DEF);

    // field widths
    localparam int MODE_W   = 2;
    localparam int KEY_W    = 31;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 10;
    localparam int COUNT_W  = 11;
    localparam int SIZE_W   = 11;
    localparam int BIT_W    = $clog2(KEY_W);

    // configuration
    localparam int                SIZE_RESET  = 1024;
    localparam int                DATA_W      = 32;
    localparam int                ADDR_W      = 3;
    localparam logic              REG_TABLE_SIZE = 1'b0;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_READ  = 5'b00100,
        S_CHECK = 5'b01000,
        S_CLEAR = 5'b10000
    } state_t;

endpackage

### hdl/qpht_modadd.sv
`timescale 1ns / 1ps

module qpht_modadd #(
    parameter int W = qpht_pkg::IDX_W_DEF
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic         cin,
    input  logic [W:0]   n,
    output logic [W-1:0] y
);

    logic [W:0] sum;
    logic [W:0] diff;

    // operands stay below n, so one subtract brings the sum back into range
    assign sum  = {1'b0, a} + {1'b0, b} + {{W{1'b0}}, cin};
    assign diff = sum - n;
    assign y    = (sum >= n) ? diff[W-1:0] : sum[W-1:0];

endmodule

### hdl/quadratic_probe_hash_table.sv
`timescale 1ns / 1ps

// Open-addressing hash table of 31-bit keys with quadratic probing over an
// on-chip store with one write port and one registered read port. A command
// is taken when start is high and busy is low; every command returns one
// word on status/slot/probe_count with done high for exactly one cycle, and
// the receiver cannot stall it. Insert and search first reduce the key
// modulo the table size one bit a cycle, from the top bit, then each probe
// takes a store read and a compare; one shared modular adder does the
// reduction and steps the probe slot and its stride. Clear sweeps the store
// one entry a cycle, then reports cleared. After reset the same sweep runs
// with busy high and no result. A zero key or an unknown mode answers
// straight from the idle state, with no search.

module quadratic_probe_hash_table #(
    parameter int TABLE_DEPTH = qpht_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // command
    input  logic                           start,
    output logic                           busy,
    input  logic [qpht_pkg::MODE_W-1:0]    mode,
    input  logic [qpht_pkg::KEY_W-1:0]     key,
    // result
    output logic                           done,
    output logic [qpht_pkg::STATUS_W-1:0]  status,
    output logic [qpht_pkg::SLOT_W-1:0]    slot,
    output logic [qpht_pkg::COUNT_W-1:0]   probe_count,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qpht_pkg::ADDR_W-1:0]    paddr,
    input  logic [qpht_pkg::DATA_W-1:0]    pwdata,
    output logic [qpht_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);

    localparam int IW     = $clog2(TABLE_DEPTH);
    localparam int CW     = $clog2(TABLE_DEPTH + 2);
    localparam int KW     = qpht_pkg::KEY_W;
    localparam int BW     = qpht_pkg::BIT_W;
    localparam int SW     = qpht_pkg::SIZE_W;
    localparam int SLW    = qpht_pkg::SLOT_W;
    localparam int CNW    = qpht_pkg::COUNT_W;
    localparam int STW    = qpht_pkg::STATUS_W;

    qpht_pkg::state_t state_reg, state_next;

    logic [SW-1:0]  table_size_reg;
    logic [KW-1:0]  key_reg, key_next;
    logic [qpht_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [BW-1:0]  bit_reg, bit_next;
    logic [IW-1:0]  cur_reg, cur_next;
    logic [IW-1:0]  stride_reg, stride_next;
    logic [IW-1:0]  probe_slot_reg, probe_slot_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [IW-1:0]  clr_reg, clr_next;
    logic           clr_report_reg, clr_report_next;

    logic           done_reg, done_next;
    logic [STW-1:0] status_reg, status_next;
    logic [SLW-1:0] slot_reg, slot_next;
    logic [CNW-1:0] probe_count_reg, probe_count_next;

    logic [KW-1:0]  slot_store [TABLE_DEPTH];
    logic [KW-1:0]  rd_data_reg;
    logic           mem_we;
    logic [IW-1:0]  mem_waddr;
    logic [KW-1:0]  mem_wdata;

    logic [IW:0]    n_eff;
    logic [IW-1:0]  two_mod;
    logic [CW-1:0]  n_cnt;
    logic [CW-1:0]  count_inc;

    logic [IW-1:0]  alu_a;
    logic [IW-1:0]  alu_b;
    logic           alu_cin;
    logic [IW-1:0]  alu_y;

    logic           accept;
    logic           cfg_wr;

    // handshake
    assign accept = start && !busy;
    assign busy   = (state_reg != qpht_pkg::S_IDLE);

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == qpht_pkg::REG_TABLE_SIZE);
    assign prdata = (paddr[2] == qpht_pkg::REG_TABLE_SIZE)
                    ? {{(qpht_pkg::DATA_W - SW){1'b0}}, table_size_reg}
                    : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= SW'(qpht_pkg::SIZE_RESET);
        end
        else if (cfg_wr)
        begin
            table_size_reg <= pwdata[SW-1:0];
        end
    end

    // effective modulus, table size clamped to 1..TABLE_DEPTH
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            n_eff = (IW + 1)'(1);
        end
        else if (32'(table_size_reg) > TABLE_DEPTH)
        begin
            n_eff = (IW + 1)'(TABLE_DEPTH);
        end
        else
        begin
            n_eff = (IW + 1)'(table_size_reg);
        end
    end

    // stride step of the probe sequence is 2 mod n
    assign two_mod   = (n_eff <= (IW + 1)'(2)) ? '0 : IW'(2);
    assign n_cnt     = CW'(n_eff);
    assign count_inc = count_reg + CW'(1);

    // shared modular adder operands
    always_comb
    begin
        case (state_reg)
            qpht_pkg::S_DIV:
            begin
                alu_a   = cur_reg;
                alu_b   = cur_reg;
                alu_cin = key_reg[bit_reg];
            end
            qpht_pkg::S_READ:
            begin
                alu_a   = cur_reg;
                alu_b   = stride_reg;
                alu_cin = 1'b0;
            end
            qpht_pkg::S_CHECK:
            begin
                alu_a   = stride_reg;
                alu_b   = two_mod;
                alu_cin = 1'b0;
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_cin = 1'b0;
            end
        endcase
    end

    qpht_modadd #(
        .W (IW)
    ) u_modadd (
        .a   (alu_a),
        .b   (alu_b),
        .cin (alu_cin),
        .n   (n_eff),
        .y   (alu_y)
    );

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        key_next         = key_reg;
        mode_next        = mode_reg;
        bit_next         = bit_reg;
        cur_next         = cur_reg;
        stride_next      = stride_reg;
        probe_slot_next  = probe_slot_reg;
        count_next       = count_reg;
        clr_next         = clr_reg;
        clr_report_next  = clr_report_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        slot_next        = slot_reg;
        probe_count_next = probe_count_reg;
        mem_we           = 1'b0;
        mem_waddr        = clr_reg;
        mem_wdata        = '0;

        case (state_reg)
            qpht_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    key_next  = key;
                    mode_next = mode;
                    case (mode)
                        qpht_pkg::MODE_CLEAR:
                        begin
                            clr_next        = '0;
                            clr_report_next = 1'b1;
                            state_next      = qpht_pkg::S_CLEAR;
                        end
                        qpht_pkg::MODE_INSERT, qpht_pkg::MODE_SEARCH:
                        begin
                            if (key == '0)
                            begin
                                done_next        = 1'b1;
                                status_next      = (mode == qpht_pkg::MODE_INSERT)
                                                   ? qpht_pkg::ST_FULL
                                                   : qpht_pkg::ST_NOT_FOUND;
                                slot_next        = '0;
                                probe_count_next = '0;
                            end
                            else
                            begin
                                cur_next   = '0;
                                bit_next   = BW'(KW - 1);
                                state_next = qpht_pkg::S_DIV;
                            end
                        end
                        default:
                        begin
                            done_next        = 1'b1;
                            status_next      = qpht_pkg::ST_NOT_FOUND;
                            slot_next        = '0;
                            probe_count_next = '0;
                        end
                    endcase
                end
            end

            // key mod n, one key bit a cycle from the top
            qpht_pkg::S_DIV:
            begin
                cur_next = alu_y;
                bit_next = bit_reg - BW'(1);
                if (bit_reg == '0)
                begin
                    stride_next = two_mod;
                    count_next  = '0;
                    state_next  = qpht_pkg::S_READ;
                end
            end

            // read the slot, step to the next probe slot
            qpht_pkg::S_READ:
            begin
                probe_slot_next = cur_reg;
                cur_next        = alu_y;
                state_next      = qpht_pkg::S_CHECK;
            end

            // compare the slot contents, widen the stride
            qpht_pkg::S_CHECK:
            begin
                stride_next = alu_y;
                count_next  = count_inc;
                state_next  = qpht_pkg::S_READ;
                if (rd_data_reg == key_reg)
                begin
                    done_next        = 1'b1;
                    status_next      = (mode_reg == qpht_pkg::MODE_INSERT)
                                       ? qpht_pkg::ST_PRESENT
                                       : qpht_pkg::ST_FOUND;
                    slot_next        = SLW'(probe_slot_reg);
                    probe_count_next = CNW'(count_inc);
                    state_next       = qpht_pkg::S_IDLE;
                end
                else if (mode_reg == qpht_pkg::MODE_INSERT)
                begin
                    if (rd_data_reg == '0)
                    begin
                        mem_we           = 1'b1;
                        mem_waddr        = probe_slot_reg;
                        mem_wdata        = key_reg;
                        done_next        = 1'b1;
                        status_next      = qpht_pkg::ST_INSERTED;
                        slot_next        = SLW'(probe_slot_reg);
                        probe_count_next = CNW'(count_inc);
                        state_next       = qpht_pkg::S_IDLE;
                    end
                    else if (count_inc == n_cnt + CW'(1))
                    begin
                        done_next        = 1'b1;
                        status_next      = qpht_pkg::ST_FULL;
                        slot_next        = '0;
                        probe_count_next = CNW'(count_inc);
                        state_next       = qpht_pkg::S_IDLE;
                    end
                end
                else if ((rd_data_reg == '0) || (count_inc >= n_cnt))
                begin
                    done_next        = 1'b1;
                    status_next      = qpht_pkg::ST_NOT_FOUND;
                    slot_next        = '0;
                    probe_count_next = CNW'(count_inc);
                    state_next       = qpht_pkg::S_IDLE;
                end
            end

            // zero the store one entry a cycle
            qpht_pkg::S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + IW'(1);
                if (clr_reg == IW'(TABLE_DEPTH - 1))
                begin
                    state_next = qpht_pkg::S_IDLE;
                    if (clr_report_reg)
                    begin
                        done_next        = 1'b1;
                        status_next      = qpht_pkg::ST_CLEARED;
                        slot_next        = '0;
                        probe_count_next = '0;
                    end
                end
            end

            default:
            begin
                state_next = qpht_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= qpht_pkg::S_CLEAR;
            clr_reg        <= '0;
            clr_report_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            clr_report_reg <= clr_report_next;
            done_reg       <= done_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
        mode_reg        <= mode_next;
        bit_reg         <= bit_next;
        cur_reg         <= cur_next;
        stride_reg      <= stride_next;
        probe_slot_reg  <= probe_slot_next;
        count_reg       <= count_next;
        status_reg      <= status_next;
        slot_reg        <= slot_next;
        probe_count_reg <= probe_count_next;
    end

    // slot store, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_store[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= slot_store[cur_reg];
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign slot        = slot_reg;
    assign probe_count = probe_count_reg;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

// one result word as it appears on status/slot/probe_count
typedef struct packed {
    logic [qpht_pkg::STATUS_W-1:0] status;
    logic [qpht_pkg::SLOT_W-1:0]   slot;
    logic [qpht_pkg::COUNT_W-1:0]  probe_count;
} table_word_t;

// shadow of the hash table plus the words it still owes
class probe_table_model;
    logic [qpht_pkg::KEY_W-1:0]  slot_keys [qpht_pkg::TABLE_DEPTH_DEF];
    logic [qpht_pkg::SIZE_W-1:0] size_reg;
    table_word_t                 pending_results[$];
    int                          mismatch_count;

    function new();
        foreach (slot_keys[i])
            slot_keys[i] = '0;
        size_reg = (qpht_pkg::SIZE_W)'(qpht_pkg::SIZE_RESET);
        mismatch_count = 0;
    endfunction

    function void set_size(input logic [qpht_pkg::SIZE_W-1:0] v);
        size_reg = v;
    endfunction

    // size register clamped to 1..depth
    function int unsigned active_size();
        if (size_reg == '0)
            return 1;
        if (32'(size_reg) > 32'(qpht_pkg::TABLE_DEPTH_DEF))
            return 32'(qpht_pkg::TABLE_DEPTH_DEF);
        return 32'(size_reg);
    endfunction

    // exact key + i + i*i, reduced by the active size
    function int unsigned probe_index(input logic [qpht_pkg::KEY_W-1:0] k,
                                      input int unsigned i, input int unsigned n);
        longint unsigned ii;
        longint unsigned h;
        ii = 64'(i);
        h = ii * ii + ii + 64'(k);
        return 32'(h % 64'(n));
    endfunction

    task report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // apply one accepted command to the shadow table and queue its word
    function void note_command(input logic [qpht_pkg::MODE_W-1:0] m,
                               input logic [qpht_pkg::KEY_W-1:0] k);
        table_word_t w;
        int unsigned n;
        int unsigned i;
        int unsigned j;
        bit          finished;
        w = '0;
        n = active_size();
        finished = 1'b0;
        if (m == qpht_pkg::MODE_CLEAR)
        begin
            foreach (slot_keys[x])
                slot_keys[x] = '0;
            w.status = qpht_pkg::ST_CLEARED;
        end
        else if (m == qpht_pkg::MODE_INSERT && k != '0)
        begin
            for (i = 0; i <= n && !finished; i++)
            begin
                j = probe_index(k, i, n);
                if (slot_keys[j] == k)
                begin
                    w.status = qpht_pkg::ST_PRESENT;
                    w.slot = (qpht_pkg::SLOT_W)'(j);
                    w.probe_count = (qpht_pkg::COUNT_W)'(i + 1);
                    finished = 1'b1;
                end
                else if (slot_keys[j] == '0)
                begin
                    slot_keys[j] = k;
                    w.status = qpht_pkg::ST_INSERTED;
                    w.slot = (qpht_pkg::SLOT_W)'(j);
                    w.probe_count = (qpht_pkg::COUNT_W)'(i + 1);
                    finished = 1'b1;
                end
            end
            if (!finished)
            begin
                w.status = qpht_pkg::ST_FULL;
                w.probe_count = (qpht_pkg::COUNT_W)'(n + 1);
            end
        end
        else if (m == qpht_pkg::MODE_SEARCH && k != '0)
        begin
            i = 0;
            while (!finished)
            begin
                j = probe_index(k, i, n);
                i++;
                if (slot_keys[j] == k)
                begin
                    w.status = qpht_pkg::ST_FOUND;
                    w.slot = (qpht_pkg::SLOT_W)'(j);
                    w.probe_count = (qpht_pkg::COUNT_W)'(i);
                    finished = 1'b1;
                end
                else if (slot_keys[j] == '0 || i >= n)
                begin
                    w.status = qpht_pkg::ST_NOT_FOUND;
                    w.probe_count = (qpht_pkg::COUNT_W)'(i);
                    finished = 1'b1;
                end
            end
        end
        // zero key on insert reports no room
        else if (m == qpht_pkg::MODE_INSERT)
            w.status = qpht_pkg::ST_FULL;
        // zero key on search, or the unused mode
        else
            w.status = qpht_pkg::ST_NOT_FOUND;
        pending_results.push_back(w);
    endfunction

    // compare one result word with the oldest one owed
    task check_word(input logic [qpht_pkg::STATUS_W-1:0] st,
                    input logic [qpht_pkg::SLOT_W-1:0] sl,
                    input logic [qpht_pkg::COUNT_W-1:0] cnt);
        table_word_t exp_w;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word status %0d slot %0d count %0d",
                                      st, sl, cnt));
            return;
        end
        exp_w = pending_results.pop_front();
        if (st !== exp_w.status)
            report_mismatch($sformatf("status %0d, want %0d", st, exp_w.status));
        if (sl !== exp_w.slot)
            report_mismatch($sformatf("slot %0d, want %0d", sl, exp_w.slot));
        if (cnt !== exp_w.probe_count)
            report_mismatch($sformatf("probe_count %0d, want %0d", cnt, exp_w.probe_count));
    endtask
endclass

module tb;

    localparam logic [qpht_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [qpht_pkg::ADDR_W-1:0] SIZE_ADDR   =
        (qpht_pkg::ADDR_W)'(4 * int'(qpht_pkg::REG_TABLE_SIZE));
    localparam logic [qpht_pkg::KEY_W-1:0]  KEY_MAX     = 31'h7FFF_FFFF;
    localparam int QUIET_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 2200;
    localparam int PHASE_ITEMS = 150;
    localparam int PHASES      = 13;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    logic [qpht_pkg::MODE_W-1:0]     mode = '0;
    logic [qpht_pkg::KEY_W-1:0]      key = '0;
    logic                            done;
    logic [qpht_pkg::STATUS_W-1:0]   status;
    logic [qpht_pkg::SLOT_W-1:0]     slot;
    logic [qpht_pkg::COUNT_W-1:0]    probe_count;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [qpht_pkg::ADDR_W-1:0]     paddr = '0;
    logic [qpht_pkg::DATA_W-1:0]     pwdata = '0;
    logic [qpht_pkg::DATA_W-1:0]     prdata;
    logic                            pready;

    probe_table_model                sb;
    logic [qpht_pkg::KEY_W-1:0]      stored_keys[$];
    int                              quiet_cycles = 0;

    int unsigned phase_size [PHASES] = '{5, 1, 2, 16, 7, 64, 0, 31, 2047, 3, 100, 1024, 13};
    int          phase_idle [PHASES] = '{0, 67, 25, 0, 67, 25, 0, 67, 25, 0, 67, 25, 0};

    quadratic_probe_hash_table u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .key         (key),
        .done        (done),
        .status      (status),
        .slot        (slot),
        .probe_count (probe_count),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // result check, command capture and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_word(status, slot, probe_count);
            if (start && !busy)
                sb.note_command(mode, key);
            if (done || (start && !busy))
                quiet_cycles = 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
                quiet_cycles++;
        end
    end

    // hold a command until it is taken, idling first at the given rate
    task automatic send_command(input logic [qpht_pkg::MODE_W-1:0] m,
                                input logic [qpht_pkg::KEY_W-1:0] k,
                                input int idle_pct);
        while (int'($urandom_range(99)) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        mode  <= m;
        key   <= k;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drop_start();
        @(negedge clk);
        start <= 1'b0;
    endtask

    // wait until every owed word has come and the block is free
    task automatic wait_for_results();
        while (sb.pending_results.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic apb_write(input logic [qpht_pkg::ADDR_W-1:0] a,
                             input logic [qpht_pkg::DATA_W-1:0] d);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [qpht_pkg::ADDR_W-1:0] a,
                            output logic [qpht_pkg::DATA_W-1:0] d);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= a;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        d = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // resize only with the block idle, then read the register back
    task automatic set_table_size(input logic [qpht_pkg::SIZE_W-1:0] v);
        logic [qpht_pkg::DATA_W-1:0] rd;
        drop_start();
        wait_for_results();
        apb_write(SIZE_ADDR, (qpht_pkg::DATA_W)'(v));
        sb.set_size(v);
        apb_read(SIZE_ADDR, rd);
        if (rd !== (qpht_pkg::DATA_W)'(v))
            sb.report_mismatch($sformatf("table_size reads %0d, want %0d", rd, v));
    endtask

    // small keys crowd the table, wide keys reach the high bits
    function automatic logic [qpht_pkg::KEY_W-1:0] fresh_key(input int unsigned n);
        if ($urandom_range(1) == 0)
            return (qpht_pkg::KEY_W)'($urandom_range(4 * n + 4, 1));
        return (qpht_pkg::KEY_W)'($urandom_range(32'(KEY_MAX), 1));
    endfunction

    function automatic logic [qpht_pkg::KEY_W-1:0] known_key(input int unsigned n);
        if (stored_keys.size() == 0)
            return fresh_key(n);
        return stored_keys[$urandom_range(stored_keys.size() - 1)];
    endfunction

    // mostly inserts and searches over recent keys, some clears and noise
    task automatic random_command(input int unsigned n,
                                  output logic [qpht_pkg::MODE_W-1:0] m,
                                  output logic [qpht_pkg::KEY_W-1:0] k);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 2)
        begin
            m = qpht_pkg::MODE_CLEAR;
            k = (qpht_pkg::KEY_W)'($urandom);
        end
        else if (r < 5)
        begin
            m = MODE_UNUSED;
            k = (qpht_pkg::KEY_W)'($urandom);
        end
        else if (r < 7)
        begin
            m = r[0] ? qpht_pkg::MODE_INSERT : qpht_pkg::MODE_SEARCH;
            k = '0;
        end
        else if (r < 52)
        begin
            m = qpht_pkg::MODE_INSERT;
            k = ($urandom_range(3) == 0) ? known_key(n) : fresh_key(n);
            stored_keys.push_back(k);
            if (stored_keys.size() > 256)
                void'(stored_keys.pop_front());
        end
        else
        begin
            m = qpht_pkg::MODE_SEARCH;
            k = ($urandom_range(9) < 7) ? known_key(n) : fresh_key(n);
        end
    endtask

    initial
    begin
        logic [qpht_pkg::MODE_W-1:0] m;
        logic [qpht_pkg::KEY_W-1:0]  k;
        int unsigned                 n;

        sb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // let the power-up sweep finish
        @(posedge clk);
        wait_for_results();

        // directed: reset size, collisions, key extremes, zero key, unused mode
        send_command(qpht_pkg::MODE_INSERT, 31'd1, 0);
        send_command(qpht_pkg::MODE_INSERT, 31'd1, 0);
        send_command(qpht_pkg::MODE_INSERT, KEY_MAX, 0);
        send_command(qpht_pkg::MODE_INSERT, 31'd1025, 0);
        send_command(qpht_pkg::MODE_SEARCH, 31'd1025, 0);
        send_command(qpht_pkg::MODE_SEARCH, KEY_MAX, 0);
        send_command(qpht_pkg::MODE_SEARCH, 31'd2, 0);
        send_command(qpht_pkg::MODE_INSERT, '0, 0);
        send_command(qpht_pkg::MODE_SEARCH, '0, 0);
        send_command(MODE_UNUSED, 31'd5, 0);
        send_command(qpht_pkg::MODE_CLEAR, KEY_MAX, 0);
        send_command(qpht_pkg::MODE_SEARCH, 31'd1, 0);
        // size zero acts as one slot
        set_table_size(11'd0);
        send_command(qpht_pkg::MODE_INSERT, 31'd3, 0);
        send_command(qpht_pkg::MODE_INSERT, 31'd4, 0);
        send_command(qpht_pkg::MODE_SEARCH, 31'd4, 0);
        send_command(qpht_pkg::MODE_SEARCH, 31'd3, 0);
        // oversize acts as full depth
        set_table_size(11'd2047);
        send_command(qpht_pkg::MODE_INSERT, 31'd1000, 0);
        send_command(qpht_pkg::MODE_SEARCH, 31'd3, 0);
        // shrunk table hides the high slots until it grows back
        set_table_size(11'd8);
        send_command(qpht_pkg::MODE_SEARCH, 31'd1000, 0);
        send_command(qpht_pkg::MODE_INSERT, 31'd1000, 0);
        set_table_size(11'd1024);
        send_command(qpht_pkg::MODE_SEARCH, 31'd1000, 0);
        // two slots, probe offsets are always even: each key keeps its parity slot
        set_table_size(11'd2);
        send_command(qpht_pkg::MODE_CLEAR, '0, 0);
        send_command(qpht_pkg::MODE_INSERT, 31'd2, 0);
        send_command(qpht_pkg::MODE_INSERT, 31'd4, 0);
        send_command(MODE_UNUSED, '0, 0);

        // random phases over several sizes and idle rates
        for (int p = 0; p < PHASES; p++)
        begin
            set_table_size((qpht_pkg::SIZE_W)'(phase_size[p]));
            n = sb.active_size();
            for (int it = 0; it < PHASE_ITEMS; it++)
            begin
                // hold off until the block is idle and every owed word has come, once per phase
                if (it == PHASE_ITEMS / 2)
                begin
                    drop_start();
                    wait_for_results();
                end
                random_command(n, m, k);
                send_command(m, k, phase_idle[p]);
            end
        end

        drop_start();
        wait_for_results();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.mismatch_count == 0 && sb.pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
